@@ rtl/sfsc_pkg.sv @@
// Shared constants, request and result types for the stack frame segment checker.
package sfsc_pkg;

    localparam int FRAME_DEPTH = 128;
    localparam int ADDR_W      = 32;
    localparam int FRAME_IDX_W = $clog2(FRAME_DEPTH);
    localparam int SEG_W       = 8;
    localparam int COUNT_W     = 7;
    localparam int PDATA_W     = 32;
    localparam int PADDR_W     = 4;

    localparam logic signed [SEG_W-1:0] SEG_DATA = -8'sd2;
    localparam logic signed [SEG_W-1:0] SEG_HEAP = -8'sd1;

    typedef enum logic [1:0] {
        REQ_PUSH     = 2'd0,
        REQ_POP      = 2'd1,
        REQ_CLASSIFY = 2'd2,
        REQ_NONE     = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        REG_START_BASE = 2'd0,
        REG_DATA_END   = 2'd1,
        REG_STACK_TOP  = 2'd2,
        REG_SPARE      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] current_base;
        logic [ADDR_W-1:0] stack_ptr;
    } req_t;

    typedef struct packed {
        logic signed [SEG_W-1:0] segment;
        logic [COUNT_W-1:0]      frame_count;
        logic                    overflow;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic step;
        logic push_write;
        logic pop_commit;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        req_code_t req_code;
        logic      cursor_zero;
        logic      cursor_one;
        logic      keep_walking;
        logic      in_data;
        logic      stack_hit;
        logic      out_free;
    } dp_status_t;

endpackage

@@ rtl/sfsc_cfg.sv @@
// APB configuration registers: start base, data segment end, stack top.
module sfsc_cfg
    import sfsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [ADDR_W-1:0]  data_end,
    output logic [ADDR_W-1:0]  stack_top
);

    logic [ADDR_W-1:0] start_base_reg;
    logic [ADDR_W-1:0] data_end_reg;
    logic [ADDR_W-1:0] stack_top_reg;
    logic              wr_en;
    reg_idx_t          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    // Write the addressed register at the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_base_reg <= '0;
            data_end_reg   <= '0;
            stack_top_reg  <= ADDR_W'(32'hFFFF_FFFF);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_START_BASE: start_base_reg <= ADDR_W'(pwdata);
                REG_DATA_END:   data_end_reg   <= ADDR_W'(pwdata);
                REG_STACK_TOP:  stack_top_reg  <= ADDR_W'(pwdata);
                default:        ;
            endcase
        end
    end

    // Return the addressed register on reads
    always_comb
    begin
        case (reg_idx)
            REG_START_BASE: prdata = PDATA_W'(start_base_reg);
            REG_DATA_END:   prdata = PDATA_W'(data_end_reg);
            REG_STACK_TOP:  prdata = PDATA_W'(stack_top_reg);
            default:        prdata = '0;
        endcase
    end

    assign data_end  = data_end_reg;
    assign stack_top = stack_top_reg;

endmodule

@@ rtl/sfsc_dp.sv @@
// Datapath: held request, frame base memory, walk cursor, top index and result register.
module sfsc_dp
    import sfsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  req_t              req_data,
    input  logic [ADDR_W-1:0] data_end,
    input  logic [ADDR_W-1:0] stack_top,
    input  ctl_cmd_t          cmd,
    output dp_status_t        status,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp_data
);

    logic [ADDR_W-1:0]      frame_mem [FRAME_DEPTH];
    req_t                   req_hold_reg;
    logic [FRAME_IDX_W-1:0] top_reg;
    logic [FRAME_IDX_W-1:0] top_next;
    logic [FRAME_IDX_W-1:0] cursor_reg;
    logic [ADDR_W-1:0]      base_rd_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_data_reg;
    logic [FRAME_IDX_W-1:0] top_inc;
    logic                   full;
    req_code_t              req_code;
    logic                   in_data;
    logic                   stack_hit;
    logic signed [SEG_W-1:0] seg_value;

    assign req_code  = req_code_t'(req_hold_reg.req_type);
    assign top_inc   = top_reg + FRAME_IDX_W'(1);
    assign full      = (top_reg == FRAME_IDX_W'(FRAME_DEPTH - 1));
    assign in_data   = req_hold_reg.address < data_end;
    assign stack_hit = (req_hold_reg.address >= req_hold_reg.stack_ptr) &&
                       (req_hold_reg.address <= stack_top);

    // Hold the request and set the walk cursor at the newest frame
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_hold_reg <= req_data;
            cursor_reg   <= top_reg;
        end
        else if (cmd.step)
        begin
            cursor_reg <= cursor_reg - FRAME_IDX_W'(1);
        end
    end

    // Frame base memory: one write port for push, registered read at the cursor
    always_ff @(posedge clk)
    begin
        if (cmd.push_write && !full)
        begin
            frame_mem[top_inc] <= req_hold_reg.address;
        end
        base_rd_reg <= frame_mem[cursor_reg];
    end

    // Advance or pull back the top index
    always_comb
    begin
        if (cmd.push_write && !full)
        begin
            top_next = top_inc;
        end
        else if (cmd.pop_commit)
        begin
            top_next = cursor_reg;
        end
        else
        begin
            top_next = top_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else
        begin
            top_reg <= top_next;
        end
    end

    // Pick the segment code for a classify request
    always_comb
    begin
        if (req_code != REQ_CLASSIFY)
        begin
            seg_value = '0;
        end
        else if (in_data)
        begin
            seg_value = SEG_DATA;
        end
        else if (!stack_hit)
        begin
            seg_value = SEG_HEAP;
        end
        else
        begin
            seg_value = SEG_W'(cursor_reg);
        end
    end

    // Output register: load the result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_data_reg.segment     <= seg_value;
            rsp_data_reg.frame_count <= COUNT_W'(top_next);
            rsp_data_reg.overflow    <= (req_code == REQ_PUSH) && full;
        end
    end

    // Status towards the controller
    always_comb
    begin
        status.req_code    = req_code;
        status.cursor_zero = (cursor_reg == '0);
        status.cursor_one  = (cursor_reg == FRAME_IDX_W'(1));
        status.in_data     = in_data;
        status.stack_hit   = stack_hit;
        status.out_free    = !rsp_valid_reg || rsp_ready;
        if (req_code == REQ_POP)
        begin
            status.keep_walking = base_rd_reg < req_hold_reg.current_base;
        end
        else
        begin
            status.keep_walking = !(base_rd_reg > req_hold_reg.address);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

@@ rtl/sfsc_ctrl.sv @@
// Controller: sequences request capture, the frame walk and result hand-off.
module sfsc_ctrl
    import sfsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_CMP,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                case (status.req_code)
                    REQ_POP:
                        state_next = status.cursor_zero ? ST_FINISH : ST_READ;
                    REQ_CLASSIFY:
                        if (status.in_data || !status.stack_hit || status.cursor_zero)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    default:
                        state_next = ST_FINISH;
                endcase
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.keep_walking)
                begin
                    cmd.step   = 1'b1;
                    state_next = status.cursor_one ? ST_FINISH : ST_READ;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.push_write = (status.req_code == REQ_PUSH);
                    cmd.pop_commit = (status.req_code == REQ_POP);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/stack_frame_segment_checker.sv @@
// Top level of the stack frame segment checker: configuration, controller and datapath.
//
// Requests arrive on req_valid/req_ready with a req_t payload (push a frame base,
// pop frames above the current base, or classify a pointer). Every request gives
// exactly one rsp_t result on rsp_valid/rsp_ready: segment code, newest frame
// index and a push overflow flag.
// A request is taken only while no other is in progress. Push, the unused code
// and classify outside the stack go from the decide state straight to finish;
// a pop or classify that examines stored frame bases passes each through a read
// state, for the registered read of the frame base memory, and a compare state.
// The next request is taken the cycle after the result is loaded. Frame zero is
// never read from memory; the start_base register is not used by the datapath
// and is only read back over APB. Reset clears the top index to frame zero and
// the output valid flag, and loads the configuration registers with their
// defaults; memory contents are kept. When the receiver stalls, the result holds
// in the output register; the block still takes one more request and parks its
// result until the register frees. Configuration is by APB at byte addresses 0, 4
// and 8; it must be written only while idle, which the block does not enforce.
module stack_frame_segment_checker
    import sfsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req_data,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [ADDR_W-1:0] data_end;
    logic [ADDR_W-1:0] stack_top;
    ctl_cmd_t          cmd;
    dp_status_t        status;

    sfsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .data_end  (data_end),
        .stack_top (stack_top)
    );

    sfsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sfsc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .data_end  (data_end),
        .stack_top (stack_top),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

@@ rtl/sfsc_checker.sv @@
// Port-level checks for the stack frame segment checker, bound to the top level.
module sfsc_checker
    import sfsc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed or dropped");

    // No result appears in the cycle after a request is taken
    a_no_early_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result appeared too early");

    // A request is never taken right after another
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // Overflow is flagged only at full depth, with no segment code
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.overflow |->
            rsp_data.frame_count == COUNT_W'(FRAME_DEPTH - 1) && rsp_data.segment == '0)
        else $error("overflow without a full stack");

endmodule

bind stack_frame_segment_checker sfsc_checker u_sfsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

@@ tb/sv/stack_frame_segment_checker_tb.sv @@
// Self-checking testbench for the stack frame segment checker: directed rows, random traffic.
`timescale 1ns / 100ps

module stack_frame_segment_checker_tb;
    import sfsc_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int FINAL_CYCLES   = 20;

    // One directed stimulus row; typed rows carry their own expected result
    typedef struct packed {
        req_code_t               kind;
        logic [ADDR_W-1:0]       address;
        logic [ADDR_W-1:0]       current_base;
        logic [ADDR_W-1:0]       stack_ptr;
        logic                    typed;
        logic signed [SEG_W-1:0] segment;
        logic [COUNT_W-1:0]      frame_count;
        logic                    overflow;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    req_t               req_data = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_t               rsp_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Mirror of the block: configuration, frame bases and newest frame index
    logic [ADDR_W-1:0]  cfg_start_base = '0;
    logic [ADDR_W-1:0]  cfg_data_end = '0;
    logic [ADDR_W-1:0]  cfg_stack_top = '1;
    logic [ADDR_W-1:0]  frame_base_copy [FRAME_DEPTH];
    logic [COUNT_W-1:0] newest_frame = '0;

    rsp_t        answers_due [$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned holdoff_requests = 0;
    int unsigned holdoffs_done = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned fail_count = 0;
    int unsigned results_checked = 0;
    int unsigned n_push = 0;
    int unsigned n_pop = 0;
    int unsigned n_classify = 0;
    int unsigned n_unused = 0;
    int unsigned n_refused = 0;
    int unsigned deepest = 0;

    stack_frame_segment_checker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // Push, pop or classify against the mirrored frame stack; return the answer
    function automatic rsp_t track_and_classify(input req_t r);
        rsp_t              ans;
        logic [COUNT_W-1:0] walk;
        ans = '0;
        case (r.req_type)
            REQ_PUSH:
            begin
                if (newest_frame == COUNT_W'(FRAME_DEPTH - 1))
                begin
                    ans.overflow = 1'b1;
                end
                else
                begin
                    newest_frame = newest_frame + 1'b1;
                    frame_base_copy[newest_frame] = r.address;
                end
            end
            REQ_POP:
            begin
                while (newest_frame != 0 && frame_base_copy[newest_frame] < r.current_base)
                begin
                    newest_frame = newest_frame - 1'b1;
                end
            end
            REQ_CLASSIFY:
            begin
                if (r.address < cfg_data_end)
                begin
                    ans.segment = SEG_DATA;
                end
                else if (r.address < r.stack_ptr || r.address > cfg_stack_top)
                begin
                    ans.segment = SEG_HEAP;
                end
                else
                begin
                    walk = newest_frame;
                    while (walk != 0 && !(frame_base_copy[walk] > r.address))
                    begin
                        walk = walk - 1'b1;
                    end
                    ans.segment = SEG_W'(walk);
                end
            end
            default:
            begin
            end
        endcase
        ans.frame_count = newest_frame;
        return ans;
    endfunction

    function automatic req_t pack_request(input req_code_t kind, input logic [ADDR_W-1:0] a,
                                          input logic [ADDR_W-1:0] c,
                                          input logic [ADDR_W-1:0] s);
        req_t r;
        r.req_type     = kind;
        r.address      = a;
        r.current_base = c;
        r.stack_ptr    = s;
        return r;
    endfunction

    function automatic dir_row_t dir_row(input req_code_t kind, input logic [ADDR_W-1:0] a,
                                         input logic [ADDR_W-1:0] c,
                                         input logic [ADDR_W-1:0] s, input logic typed,
                                         input logic signed [SEG_W-1:0] seg,
                                         input logic [COUNT_W-1:0] cnt, input logic ovf);
        dir_row_t row;
        row.kind         = kind;
        row.address      = a;
        row.current_base = c;
        row.stack_ptr    = s;
        row.typed        = typed;
        row.segment      = seg;
        row.frame_count  = cnt;
        row.overflow     = ovf;
        return row;
    endfunction

    // Mostly well-formed traffic: downward pushes, pops to a known frame base,
    // pointers around stored bases; the rest is noise with any request code
    function automatic req_t make_random_request();
        req_t              r;
        int unsigned       pick;
        int unsigned       j;
        logic [ADDR_W-1:0] newest_base;
        r.req_type     = REQ_NONE;
        r.address      = $urandom;
        r.current_base = $urandom;
        r.stack_ptr    = $urandom;
        pick           = $urandom_range(99);
        newest_base    = frame_base_copy[newest_frame];
        if (pick < 10)
        begin
            r.req_type = 2'($urandom_range(3));
        end
        else if (pick < 45)
        begin
            r.req_type = REQ_PUSH;
            if (newest_base > 32'h0000_2000 && $urandom_range(9) != 0)
            begin
                r.address = newest_base - 32'($urandom_range(4096, 16));
            end
        end
        else if (pick < 62)
        begin
            r.req_type = REQ_POP;
            j = $urandom_range(newest_frame);
            if ($urandom_range(9) != 0)
            begin
                r.current_base = frame_base_copy[j] + 32'($urandom_range(1));
            end
        end
        else
        begin
            r.req_type = REQ_CLASSIFY;
            j = $urandom_range(newest_frame);
            case ($urandom_range(4))
                0, 1, 2: r.address = frame_base_copy[j] + 32'($urandom_range(64)) - 32'd32;
                3:
                begin
                    if (cfg_data_end != 0)
                    begin
                        r.address = $urandom_range(cfg_data_end - 1);
                    end
                end
                default:
                begin
                end
            endcase
            if ($urandom_range(9) != 0)
            begin
                r.stack_ptr = newest_base - 32'($urandom_range(256));
            end
        end
        return r;
    endfunction

    // Offer one request, hold it until taken, then record its answer
    task automatic send_request(input req_t r, input bit given, input rsp_t given_rsp);
        rsp_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        predicted = track_and_classify(r);
        answers_due.push_back(given ? given_rsp : predicted);
        case (r.req_type)
            REQ_PUSH:     n_push++;
            REQ_POP:      n_pop++;
            REQ_CLASSIFY: n_classify++;
            default:      n_unused++;
        endcase
        if (predicted.overflow)
        begin
            n_refused++;
        end
        if (newest_frame > deepest)
        begin
            deepest = newest_frame;
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic settle();
        req_valid <= 1'b0;
        while (answers_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_START_BASE:
            begin
                cfg_start_base     = value;
                frame_base_copy[0] = value;
            end
            REG_DATA_END:  cfg_data_end = value;
            REG_STACK_TOP: cfg_stack_top = value;
            default:
            begin
            end
        endcase
    endtask

    task automatic apb_check(input reg_idx_t idx, input logic [PDATA_W-1:0] want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata !== want)
        begin
            $error("register %s: expected %h, got %h", idx.name(), want, prdata);
            fail_count++;
        end
    endtask

    // Program all limits, poke the spare address, and read the limits back
    task automatic program_limits(input logic [ADDR_W-1:0] start_base,
                                  input logic [ADDR_W-1:0] data_end,
                                  input logic [ADDR_W-1:0] stack_top);
        apb_write(REG_START_BASE, start_base);
        apb_write(REG_DATA_END, data_end);
        apb_write(REG_STACK_TOP, stack_top);
        apb_write(REG_SPARE, $urandom);
        apb_check(REG_START_BASE, cfg_start_base);
        apb_check(REG_DATA_END, cfg_data_end);
        apb_check(REG_STACK_TOP, cfg_stack_top);
    endtask

    task automatic run_random(input int unsigned count, input int unsigned send_pct,
                              input int unsigned recv_pct, input int hold_at,
                              input int pause_at);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
            begin
                holdoff_requests++;
            end
            if (i == pause_at)
            begin
                settle();
            end
            send_request(make_random_request(), 1'b0, '0);
        end
    endtask

    // Check each result against the oldest expectation; drive ready
    always @(posedge clk)
    begin : result_sink
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result with no request outstanding: %p", rsp_data);
                fail_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                results_checked++;
                if (rsp_data.segment !== want.segment)
                begin
                    $error("segment: expected %0d, got %0d", want.segment, rsp_data.segment);
                    fail_count++;
                end
                if (rsp_data.frame_count !== want.frame_count)
                begin
                    $error("frame_count: expected %0d, got %0d", want.frame_count,
                           rsp_data.frame_count);
                    fail_count++;
                end
                if (rsp_data.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b", want.overflow, rsp_data.overflow);
                    fail_count++;
                end
            end
        end
        // Long hold-off when asked, else random stalls
        if (hold_left != 0)
        begin
            rsp_ready <= 1'b0;
            hold_left--;
        end
        else if (holdoffs_done != holdoff_requests)
        begin
            holdoffs_done++;
            hold_left = HOLDOFF_CYCLES;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        dir_row_t    directed_rows [$];
        dir_row_t    row;
        rsp_t        given;
        logic [ADDR_W-1:0] mid_base;

        foreach (frame_base_copy[k])
        begin
            frame_base_copy[k] = '0;
        end
        cfg_stack_top = '1;

        // Stack boundaries, data and heap split, frame zero, pushes and pops, unused code
        directed_rows.push_back(dir_row(REQ_CLASSIFY, 32'h0000_0000, 32'h0, 32'h0,
                                        1'b1, SEG_DATA, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_CLASSIFY, 32'h0000_00FF, 32'h0, 32'h0,
                                        1'b1, SEG_DATA, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_CLASSIFY, 32'h0000_0100, 32'h0, 32'h0000_0200,
                                        1'b1, SEG_HEAP, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_CLASSIFY, 32'hFFFF_FFFF, 32'h0, 32'h0,
                                        1'b1, SEG_HEAP, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_CLASSIFY, 32'hFFFF_0000, 32'h0, 32'h0,
                                        1'b1, 8'sd0, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_POP, 32'h0, 32'hFFFF_FFFF, 32'h0,
                                        1'b1, 8'sd0, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_PUSH, 32'h7FFF_F000, 32'h0, 32'h0,
                                        1'b1, 8'sd0, 7'd1, 1'b0));
        directed_rows.push_back(dir_row(REQ_PUSH, 32'h7FFF_E000, 32'h0, 32'h0,
                                        1'b1, 8'sd0, 7'd2, 1'b0));
        directed_rows.push_back(dir_row(REQ_PUSH, 32'h7FFF_D000, 32'h0, 32'h0,
                                        1'b1, 8'sd0, 7'd3, 1'b0));
        directed_rows.push_back(dir_row(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        1'b1, 8'sd0, 7'd3, 1'b0));
        directed_rows.push_back(dir_row(REQ_CLASSIFY, 32'h7FFF_D800, 32'h0, 32'h7000_0000,
                                        1'b0, 8'sd0, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_CLASSIFY, 32'h7FFF_C000, 32'h0, 32'h7FFF_C000,
                                        1'b0, 8'sd0, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_CLASSIFY, 32'h7FFF_F000, 32'h0, 32'h7000_0000,
                                        1'b0, 8'sd0, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_CLASSIFY, 32'hFFFF_0000, 32'h0, 32'hFFFF_0000,
                                        1'b0, 8'sd0, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_CLASSIFY, 32'h7FFF_BFFF, 32'h0, 32'h7FFF_C000,
                                        1'b0, 8'sd0, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_POP, 32'h0, 32'h7FFF_E000, 32'h0,
                                        1'b0, 8'sd0, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_PUSH, 32'hFFFF_FFFF, 32'h0, 32'h0,
                                        1'b0, 8'sd0, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_PUSH, 32'h0000_0000, 32'h0, 32'h0,
                                        1'b0, 8'sd0, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_CLASSIFY, 32'h0000_0100, 32'h0, 32'h0,
                                        1'b0, 8'sd0, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_POP, 32'h0, 32'h0000_0000, 32'h0,
                                        1'b0, 8'sd0, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_POP, 32'h0, 32'hFFFF_FFFF, 32'h0,
                                        1'b0, 8'sd0, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_NONE, 32'h0, 32'h0, 32'h0,
                                        1'b0, 8'sd0, 7'd0, 1'b0));
        directed_rows.push_back(dir_row(REQ_PUSH, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
                                        1'b0, 8'sd0, 7'd0, 1'b0));

        // Hold reset, then release on a clock edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows under a mid-range setting
        program_limits(32'h8000_0000, 32'h0000_0100, 32'hFFFF_0000);
        send_idle_pct = 15;
        recv_idle_pct = 67;
        foreach (directed_rows[k])
        begin
            row                = directed_rows[k];
            given.segment      = row.segment;
            given.frame_count  = row.frame_count;
            given.overflow     = row.overflow;
            send_request(pack_request(row.kind, row.address, row.current_base, row.stack_ptr),
                         row.typed, given);
        end
        settle();

        // Eager sender, slow receiver; one long hold-off and one sender pause
        program_limits(32'hC000_0000, 32'h1000_0000, 32'hBFFF_FFFF);
        run_random(120, 15, 67, 40, 90);
        settle();

        // Slow sender, eager receiver, widest stack range
        program_limits(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        run_random(120, 67, 15, -1, -1);
        settle();

        // Almost everything is data, stack range collapsed to address zero
        program_limits(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        run_random(30, 0, 0, -1, -1);
        settle();

        // Fill the stack to full depth, refuse pushes, walk it, then unwind
        program_limits($urandom, $urandom_range(32'h0100_0000), 32'hFFFF_FFFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (newest_frame != COUNT_W'(FRAME_DEPTH - 1))
        begin
            send_request(pack_request(REQ_PUSH, 32'hF000_0000 - 32'(newest_frame) * 32'h100,
                                      $urandom, $urandom), 1'b0, '0);
        end
        repeat (3)
        begin
            send_request(pack_request(REQ_PUSH, $urandom, $urandom, $urandom), 1'b0, '0);
        end
        send_request(pack_request(REQ_CLASSIFY, 32'hF000_0000, $urandom, 32'h0), 1'b0, '0);
        send_request(pack_request(REQ_CLASSIFY, frame_base_copy[newest_frame] - 1'b1,
                                  $urandom, 32'h0), 1'b0, '0);
        mid_base = frame_base_copy[FRAME_DEPTH / 2];
        send_request(pack_request(REQ_POP, $urandom, mid_base, $urandom), 1'b0, '0);
        send_request(pack_request(REQ_CLASSIFY, mid_base - 32'd1, $urandom, 32'h0), 1'b0, '0);
        send_request(pack_request(REQ_POP, $urandom, 32'hFFFF_FFFF, $urandom), 1'b0, '0);
        run_random(30, 0, 0, -1, -1);

        // Drain and report
        settle();
        repeat (FINAL_CYCLES) @(posedge clk);
        $display("Run covered %0d requests: %0d push, %0d pop, %0d classify, %0d unused code.",
                 n_push + n_pop + n_classify + n_unused, n_push, n_pop, n_classify, n_unused);
        $display("Checked %0d results; deepest stack %0d frames; %0d pushes refused at full depth.",
                 results_checked, deepest, n_refused);
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
